// ----- rtl/nfvr_pkg.sv -----
// Shared declarations for the normal frame vector rotate unit.
// Used by nfvr_unit and normal_frame_vector_rotate_unit; depends on nothing.

package nfvr_pkg;

	localparam int LANES = 3;

	typedef struct packed {
		logic valid;
		logic zero;
	} unit_stat_t;

endpackage

// ----- rtl/normal_frame_vector_rotate_unit.sv -----
// Top level of the normal frame vector rotate unit: tangent selection, cross product,
// final rotation with rounding and saturation, and a two-entry output queue.
// Depends on nfvr_pkg and nfvr_unit.

// The unit takes one item per clock while in_ready is high and returns one result per item,
// in order. Most of the pipeline lies in the two normalizers, each of which spends one stage
// per root bit and one stage per quotient bit. A two-entry output queue lets the pipeline
// keep accepting while a result waits; in_ready drops only when that queue is full. A zero
// normal gives a zero result with degenerate set, and a component that does not fit is
// saturated with clipped set.

module normal_frame_vector_rotate_unit #(
	parameter int COMPONENT_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [COMPONENT_WIDTH-1:0]  local_x,
	input  logic [COMPONENT_WIDTH-1:0]  local_y,
	input  logic [COMPONENT_WIDTH-1:0]  local_z,
	input  logic [COMPONENT_WIDTH-1:0]  normal_x,
	input  logic [COMPONENT_WIDTH-1:0]  normal_y,
	input  logic [COMPONENT_WIDTH-1:0]  normal_z,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [COMPONENT_WIDTH-1:0]  world_x,
	output logic [COMPONENT_WIDTH-1:0]  world_y,
	output logic [COMPONENT_WIDTH-1:0]  world_z,
	output logic                        degenerate,
	output logic                        clipped
);

	localparam int W = COMPONENT_WIDTH;
	localparam int FRAC = W - 2;
	localparam int PW = 2 * W;
	localparam int SUMW = 2 * W + 2;
	localparam int MWB = 2 * W - 1;
	localparam int SA = 3 + 6 * W;
	localparam int SB = 4 + 9 * W;
	localparam int L = nfvr_pkg::LANES;
	localparam logic [PW:0] HALF = (PW+1)'(1) << (FRAC - 1);
	localparam logic [W+2:0] Q_NMAX = (W+3)'(1) << (W - 1);
	localparam logic [W+2:0] Q_PMAX = Q_NMAX - (W+3)'(1);
	localparam logic [1:0] Q_FULL = 2'd2;

	typedef struct packed {
		logic [W-1:0] wx;
		logic [W-1:0] wy;
		logic [W-1:0] wz;
		logic         deg;
		logic         clip;
	} res_t;

	logic                       en;
	logic                       v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [L-1:0][W-1:0]        l_s1, l_s2, l_s3, l_s4, l_s5;
	logic [L-1:0][W-1:0]        n_s1, n_s2, n_s3, n_s4, n_s5;
	logic [L-1:0][W-1:0]        nabs;
	logic                       sel;
	logic [L-1:0][W-1:0]        tm;
	logic [L-1:0]               tsgn;

	nfvr_pkg::unit_stat_t       ua_stat, ub_stat;
	logic [L-1:0][W-2:0]        ua_q, ub_q;
	logic [SA-1:0]              ua_side;
	logic [SB-1:0]              ub_side;
	logic [L-1:0]               ua_tsgn;
	logic [L-1:0][W-1:0]        ua_l, ua_n;

	logic [L-1:0][W-1:0]        t_s2, t_s3, t_s4, t_s5;
	logic                       deg_s2, deg_s3, deg_s4, deg_s5, deg_s6, deg_s7, deg_s8;
	logic signed [PW-1:0]       pr_s3 [6];
	logic [L-1:0][PW-1:0]       bx_s4;
	logic [L-1:0][MWB-1:0]      babs;
	logic [L-1:0]               bsgn;
	logic [L-1:0]               ub_bsgn;
	logic                       ub_deg;
	logic [L-1:0][W-1:0]        ub_t, ub_l, ub_n;

	logic [L-1:0][W-1:0]        b_s5;
	logic signed [PW-1:0]       pb_s6 [L];
	logic signed [PW-1:0]       pn_s6 [L];
	logic signed [PW-1:0]       pt_s6 [L];
	logic signed [SUMW-1:0]     sum_s7 [L];
	logic [PW-1:0]              mag_s8 [L];
	logic [L-1:0]               neg_s8;

	logic [PW:0]                rsum;
	logic [W+2:0]               qr;
	logic [L-1:0][W-1:0]        wres;
	logic [L-1:0]               clip;
	res_t                       res;

	res_t                       q_mem_q [2];
	logic                       wr_q, rd_q;
	logic [1:0]                 cnt_q;
	logic                       push, pop;
	res_t                       head;

	assign en = cnt_q != Q_FULL;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= ua_stat.valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= ub_stat.valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_comb begin
		for (int k = 0; k < L; k++) begin
			nabs[k] = n_s1[k][W-1] ? W'(-n_s1[k]) : n_s1[k];
		end
		sel = nabs[0] > nabs[1];
		if (sel) begin
			tm[0] = nabs[2];
			tm[1] = '0;
			tm[2] = nabs[0];
			tsgn = {~n_s1[0][W-1], 1'b0, n_s1[2][W-1]};
		end else begin
			tm[0] = '0;
			tm[1] = nabs[2];
			tm[2] = nabs[1];
			tsgn = {n_s1[1][W-1], ~n_s1[2][W-1], 1'b0};
		end
	end

	nfvr_unit #(
		.W  (W),
		.MW (W),
		.SW (SA)
	) u_tangent (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.in_mag   (tm),
		.in_side  ({tsgn, l_s1, n_s1}),
		.out_stat (ua_stat),
		.out_q    (ua_q),
		.out_side (ua_side)
	);

	assign {ua_tsgn, ua_l, ua_n} = ua_side;

	always_comb begin
		for (int k = 0; k < L; k++) begin
			babs[k] = bx_s4[k][PW-1] ? MWB'(-bx_s4[k]) : bx_s4[k][MWB-1:0];
			bsgn[k] = bx_s4[k][PW-1];
		end
	end

	nfvr_unit #(
		.W  (W),
		.MW (MWB),
		.SW (SB)
	) u_bitangent (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.in_mag   (babs),
		.in_side  ({bsgn, deg_s4, t_s4, l_s4, n_s4}),
		.out_stat (ub_stat),
		.out_q    (ub_q),
		.out_side (ub_side)
	);

	assign {ub_bsgn, ub_deg, ub_t, ub_l, ub_n} = ub_side;

	always_ff @(posedge clk) begin
		if (en) begin
			l_s1[0] <= local_x;
			l_s1[1] <= local_y;
			l_s1[2] <= local_z;
			n_s1[0] <= normal_x;
			n_s1[1] <= normal_y;
			n_s1[2] <= normal_z;

			for (int k = 0; k < L; k++) begin
				t_s2[k] <= ua_tsgn[k] ? W'(-{1'b0, ua_q[k]}) : {1'b0, ua_q[k]};
			end
			l_s2 <= ua_l;
			n_s2 <= ua_n;
			deg_s2 <= ua_stat.zero;

			pr_s3[0] <= $signed(n_s2[1]) * $signed(t_s2[2]);
			pr_s3[1] <= $signed(n_s2[2]) * $signed(t_s2[1]);
			pr_s3[2] <= $signed(n_s2[2]) * $signed(t_s2[0]);
			pr_s3[3] <= $signed(n_s2[0]) * $signed(t_s2[2]);
			pr_s3[4] <= $signed(n_s2[0]) * $signed(t_s2[1]);
			pr_s3[5] <= $signed(n_s2[1]) * $signed(t_s2[0]);
			l_s3 <= l_s2;
			n_s3 <= n_s2;
			t_s3 <= t_s2;
			deg_s3 <= deg_s2;

			bx_s4[0] <= pr_s3[0] - pr_s3[1];
			bx_s4[1] <= pr_s3[2] - pr_s3[3];
			bx_s4[2] <= pr_s3[4] - pr_s3[5];
			l_s4 <= l_s3;
			n_s4 <= n_s3;
			t_s4 <= t_s3;
			deg_s4 <= deg_s3;

			for (int k = 0; k < L; k++) begin
				b_s5[k] <= ub_bsgn[k] ? W'(-{1'b0, ub_q[k]}) : {1'b0, ub_q[k]};
			end
			l_s5 <= ub_l;
			n_s5 <= ub_n;
			t_s5 <= ub_t;
			deg_s5 <= ub_deg;

			for (int k = 0; k < L; k++) begin
				pb_s6[k] <= $signed(l_s5[0]) * $signed(b_s5[k]);
				pn_s6[k] <= $signed(l_s5[1]) * $signed(n_s5[k]);
				pt_s6[k] <= $signed(l_s5[2]) * $signed(t_s5[k]);
			end
			deg_s6 <= deg_s5;

			for (int k = 0; k < L; k++) begin
				sum_s7[k] <= pb_s6[k] + pn_s6[k] + pt_s6[k];
			end
			deg_s7 <= deg_s6;

			for (int k = 0; k < L; k++) begin
				mag_s8[k] <= sum_s7[k][SUMW-1] ? PW'(-sum_s7[k]) : PW'(sum_s7[k]);
				neg_s8[k] <= sum_s7[k][SUMW-1];
			end
			deg_s8 <= deg_s7;
		end
	end

	always_comb begin
		rsum = '0;
		qr = '0;
		for (int k = 0; k < L; k++) begin
			rsum = {1'b0, mag_s8[k]} + HALF;
			qr = rsum[PW:FRAC];
			if (neg_s8[k]) begin
				clip[k] = qr > Q_NMAX;
				wres[k] = clip[k] ? {1'b1, {(W-1){1'b0}}} : W'(-qr[W-1:0]);
			end else begin
				clip[k] = qr > Q_PMAX;
				wres[k] = clip[k] ? {1'b0, {(W-1){1'b1}}} : qr[W-1:0];
			end
		end
		if (deg_s8) begin
			res = '{wx: '0, wy: '0, wz: '0, deg: 1'b1, clip: 1'b0};
		end else begin
			res = '{wx: wres[0], wy: wres[1], wz: wres[2], deg: 1'b0, clip: |clip};
		end
	end

	assign push = en && v_s8;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_q] <= res;
		end
	end

	assign head = q_mem_q[rd_q];
	assign out_valid = cnt_q != 2'd0;
	assign world_x = head.wx;
	assign world_y = head.wy;
	assign world_z = head.wz;
	assign degenerate = head.deg;
	assign clipped = head.clip;

`ifndef SYNTHESIS
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |->
		(world_x == '0 && world_y == '0 && world_z == '0 && !clipped))
		else $error("Degenerate item carries a nonzero result.");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && !pop) |=> $stable(v_s8) && $stable(cnt_q))
		else $error("Pipeline moved during a stall.");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("Output queue count exceeded its depth.");
`endif

endmodule

// ----- rtl/nfvr_unit.sv -----
// Pipelined vector normalizer: block-exponent shift, sum of squares, one-bit-per-stage
// square root and three one-bit-per-stage dividers. Depends on nfvr_pkg.

module nfvr_unit #(
	parameter int W = 16,
	parameter int MW = 16,
	parameter int SW = 1
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_valid,
	input  logic [nfvr_pkg::LANES-1:0][MW-1:0]      in_mag,
	input  logic [SW-1:0]                           in_side,
	output nfvr_pkg::unit_stat_t                    out_stat,
	output logic [nfvr_pkg::LANES-1:0][W-2:0]       out_q,
	output logic [SW-1:0]                           out_side
);

	localparam int FRAC = W - 2;
	localparam int QW = W - 1;
	localparam int PB = $clog2(MW);
	localparam int SQW = 2 * W;
	localparam int RW = W + 3;
	localparam int NW = 2 * W - 2;
	localparam logic [PB-1:0] TOP_POS = PB'(W - 2);

	typedef struct packed {
		logic [SQW-1:0]                           sum;
		logic [RW-1:0]                            rem;
		logic [W-1:0]                             root;
		logic [nfvr_pkg::LANES-1:0][W-2:0]        nm;
		logic                                     zero;
		logic [SW-1:0]                            side;
	} rt_t;

	typedef struct packed {
		logic [nfvr_pkg::LANES-1:0][NW-1:0]       n;
		logic [nfvr_pkg::LANES-1:0][W-1:0]        rem;
		logic [nfvr_pkg::LANES-1:0][QW-1:0]       quo;
		logic [W-1:0]                             r;
		logic                                     zero;
		logic [SW-1:0]                            side;
	} dv_t;

	logic                                   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [nfvr_pkg::LANES-1:0][MW-1:0]     mag_s1, mag_s2;
	logic [SW-1:0]                          side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [MW-1:0]                          big_or;
	logic [PB-1:0]                          msb;
	logic [PB-1:0]                          amt_s2;
	logic                                   right_s2;
	logic                                   zero_s2, zero_s3, zero_s4, zero_s5;
	logic [nfvr_pkg::LANES-1:0][W-2:0]      nm_c, nm_s3, nm_s4, nm_s5;
	logic [MW+W-1:0]                        wide;
	logic [MW+W-1:0]                        shifted;
	logic [nfvr_pkg::LANES-1:0][2*W-3:0]    sq_s4;
	logic [SQW-1:0]                         sum_s5;
	rt_t                                    rt_s [W];
	logic                                   rt_v_s [W];
	dv_t                                    de_s, de_c;
	logic                                   de_v_s;
	dv_t                                    dv_s [QW];
	logic                                   dv_v_s [QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			de_v_s <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			de_v_s <= rt_v_s[W-1];
		end
	end

	always_comb begin
		big_or = '0;
		for (int i = 0; i < nfvr_pkg::LANES; i++) begin
			big_or = big_or | mag_s1[i];
		end
		msb = '0;
		for (int i = 0; i < MW; i++) begin
			if (big_or[i]) begin
				msb = PB'(i);
			end
		end
	end

	always_comb begin
		wide = '0;
		shifted = '0;
		for (int i = 0; i < nfvr_pkg::LANES; i++) begin
			wide = {{W{1'b0}}, mag_s2[i]};
			shifted = right_s2 ? (wide >> amt_s2) : (wide << amt_s2);
			nm_c[i] = shifted[W-2:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= in_mag;
			side_s1 <= in_side;

			mag_s2 <= mag_s1;
			right_s2 <= msb > TOP_POS;
			amt_s2 <= (msb > TOP_POS) ? (msb - TOP_POS) : (TOP_POS - msb);
			zero_s2 <= big_or == '0;
			side_s2 <= side_s1;

			nm_s3 <= nm_c;
			zero_s3 <= zero_s2;
			side_s3 <= side_s2;

			for (int i = 0; i < nfvr_pkg::LANES; i++) begin
				sq_s4[i] <= (2*W-2)'(nm_s3[i]) * (2*W-2)'(nm_s3[i]);
			end
			nm_s4 <= nm_s3;
			zero_s4 <= zero_s3;
			side_s4 <= side_s3;

			sum_s5 <= SQW'(sq_s4[0]) + SQW'(sq_s4[1]) + SQW'(sq_s4[2]);
			nm_s5 <= nm_s4;
			zero_s5 <= zero_s4;
			side_s5 <= side_s4;

			de_s <= de_c;
		end
	end

	for (genvar k = 0; k < W; k++) begin : g_sqrt
		rt_t            cur;
		logic           cur_v;
		rt_t            nxt;
		logic [RW-1:0]  rsh;
		logic [RW-1:0]  trial;
		logic           ge;

		if (k == 0) begin : g_first
			assign cur = '{sum: sum_s5, rem: '0, root: '0, nm: nm_s5, zero: zero_s5,
				side: side_s5};
			assign cur_v = v_s5;
		end else begin : g_next
			assign cur = rt_s[k-1];
			assign cur_v = rt_v_s[k-1];
		end

		assign rsh = {cur.rem[RW-3:0], cur.sum[SQW-1-2*k -: 2]};
		assign trial = RW'({cur.root, 2'b01});
		assign ge = rsh >= trial;

		always_comb begin
			nxt = cur;
			nxt.rem = ge ? (rsh - trial) : rsh;
			nxt.root = {cur.root[W-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k] <= 1'b0;
			end else if (en) begin
				rt_v_s[k] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[k] <= nxt;
			end
		end
	end

	always_comb begin
		de_c.r = rt_s[W-1].root;
		de_c.zero = rt_s[W-1].zero;
		de_c.side = rt_s[W-1].side;
		de_c.quo = '0;
		for (int i = 0; i < nfvr_pkg::LANES; i++) begin
			de_c.n[i] = NW'({rt_s[W-1].nm[i], {FRAC{1'b0}}}) + NW'(rt_s[W-1].root >> 1);
			de_c.rem[i] = W'(de_c.n[i][NW-1:QW]);
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		dv_t            cur;
		logic           cur_v;
		dv_t            nxt;
		logic [W:0]     rsh;
		logic           ge;

		if (j == 0) begin : g_first
			assign cur = de_s;
			assign cur_v = de_v_s;
		end else begin : g_next
			assign cur = dv_s[j-1];
			assign cur_v = dv_v_s[j-1];
		end

		always_comb begin
			nxt = cur;
			rsh = '0;
			ge = 1'b0;
			for (int i = 0; i < nfvr_pkg::LANES; i++) begin
				rsh = {cur.rem[i], cur.n[i][QW-1-j]};
				ge = rsh >= {1'b0, cur.r};
				nxt.rem[i] = ge ? W'(rsh - {1'b0, cur.r}) : rsh[W-1:0];
				nxt.quo[i] = {cur.quo[i][QW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else if (en) begin
				dv_v_s[j] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[j] <= nxt;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < nfvr_pkg::LANES; i++) begin
			out_q[i] = dv_s[QW-1].zero ? '0 : dv_s[QW-1].quo[i];
		end
	end

	assign out_stat.valid = dv_v_s[QW-1];
	assign out_stat.zero = dv_s[QW-1].zero;
	assign out_side = dv_s[QW-1].side;

endmodule

// ----- verif/tb_normal_frame_vector_rotate_unit.sv -----
// Self-checking testbench for normal_frame_vector_rotate_unit: drives normals and local vectors,
// predicts each rotated world vector with its own fixed-point model and checks every result.
// Depends only on the RTL top level; no files or arguments are read.

module tb_normal_frame_vector_rotate_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 16;
	localparam int FRAC = CW - 2;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
		logic          deg;
		logic          clip;
	} world_t;

	class world_vector_board;
		world_t expected_world[$];
		int     errors = 0;

		static function automatic longint unsigned int_root(longint unsigned s);
			longint unsigned r, pw;
			r = 0;
			pw = 64'd1 << 62;
			while (pw > s)
				pw >>= 2;
			while (pw != 0) begin
				if (s >= r + pw) begin
					s -= r + pw;
					r = (r >> 1) + pw;
				end else begin
					r >>= 1;
				end
				pw >>= 2;
			end
			return r;
		endfunction

		static function automatic bit to_unit(input longint v[3], output longint u[3]);
			longint unsigned m[3];
			longint unsigned big, s, r, q;
			big = 0;
			s = 0;
			for (int i = 0; i < 3; i++) begin
				m[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
				if (m[i] > big)
					big = m[i];
				u[i] = 0;
			end
			if (big == 0)
				return 0;
			while (big >= (64'd1 << (CW - 1))) begin
				for (int i = 0; i < 3; i++)
					m[i] >>= 1;
				big >>= 1;
			end
			while (big < (64'd1 << (CW - 2))) begin
				for (int i = 0; i < 3; i++)
					m[i] <<= 1;
				big <<= 1;
			end
			for (int i = 0; i < 3; i++)
				s += m[i] * m[i];
			r = int_root(s);
			for (int i = 0; i < 3; i++) begin
				q = ((m[i] << FRAC) + (r >> 1)) / r;
				u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
			end
			return 1;
		endfunction

		static function automatic world_t rotate_to_world(input logic [CW-1:0] lv[3],
				input logic [CW-1:0] nv[3]);
			longint l[3], n[3], traw[3], t[3], braw[3], b[3], p[3];
			longint unsigned pos, neg, m, q;
			logic [CW-1:0] res[3];
			world_t w;
			w = '0;
			for (int k = 0; k < 3; k++) begin
				l[k] = longint'($signed(lv[k]));
				n[k] = longint'($signed(nv[k]));
			end
			if ((n[0] < 0 ? -n[0] : n[0]) > (n[1] < 0 ? -n[1] : n[1])) begin
				traw[0] = n[2]; traw[1] = 0; traw[2] = -n[0];
			end else begin
				traw[0] = 0; traw[1] = -n[2]; traw[2] = n[1];
			end
			if (!to_unit(traw, t)) begin
				w.deg = 1'b1;
				return w;
			end
			braw[0] = n[1] * t[2] - n[2] * t[1];
			braw[1] = n[2] * t[0] - n[0] * t[2];
			braw[2] = n[0] * t[1] - n[1] * t[0];
			void'(to_unit(braw, b));
			for (int k = 0; k < 3; k++) begin
				p[0] = l[0] * b[k];
				p[1] = l[1] * n[k];
				p[2] = l[2] * t[k];
				pos = 0;
				neg = 0;
				for (int j = 0; j < 3; j++) begin
					if (p[j] < 0)
						neg += longint'(-p[j]);
					else
						pos += p[j];
				end
				m = (neg > pos) ? neg - pos : pos - neg;
				q = (m + (64'd1 << (FRAC - 1))) >> FRAC;
				if (neg > pos) begin
					if (q > (64'd1 << (CW - 1))) begin
						q = 64'd1 << (CW - 1);
						w.clip = 1'b1;
					end
					res[k] = CW'(64'd0 - q);
				end else begin
					if (q > (64'd1 << (CW - 1)) - 1) begin
						q = (64'd1 << (CW - 1)) - 1;
						w.clip = 1'b1;
					end
					res[k] = CW'(q);
				end
			end
			w.x = res[0];
			w.y = res[1];
			w.z = res[2];
			return w;
		endfunction

		function void note_sample(input logic [CW-1:0] lv[3], input logic [CW-1:0] nv[3]);
			expected_world.push_back(rotate_to_world(lv, nv));
		endfunction

		function void compare(string field, longint e, longint a);
			if (e != a) begin
				$error("%s mismatch: expected %0d, actual %0d", field, e, a);
				errors++;
			end
		endfunction

		function void check_world(world_t got);
			world_t e;
			if (expected_world.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
				return;
			end
			e = expected_world.pop_front();
			compare("world_x", $signed(e.x), $signed(got.x));
			compare("world_y", $signed(e.y), $signed(got.y));
			compare("world_z", $signed(e.z), $signed(got.z));
			compare("degenerate", e.deg, got.deg);
			compare("clipped", e.clip, got.clip);
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	logic [CW-1:0] local_x, local_y, local_z;
	logic [CW-1:0] normal_x, normal_y, normal_z;
	logic          out_valid;
	logic          out_ready;
	logic [CW-1:0] world_x, world_y, world_z;
	logic          degenerate;
	logic          clipped;

	world_vector_board board = new();
	int  send_idle = 0;
	int  recv_stall = 0;
	bit  hold_off = 0;
	int  quiet_cycles = 0;

	normal_frame_vector_rotate_unit #(.COMPONENT_WIDTH(CW)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.local_x(local_x), .local_y(local_y), .local_z(local_z),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.world_x(world_x), .world_y(world_y), .world_z(world_z),
		.degenerate(degenerate), .clipped(clipped)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic send_item(input logic [CW-1:0] lv[3], input logic [CW-1:0] nv[3]);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1'b1;
		local_x <= lv[0];
		local_y <= lv[1];
		local_z <= lv[2];
		normal_x <= nv[0];
		normal_y <= nv[1];
		normal_z <= nv[2];
		do @(posedge clk); while (!in_ready);
		board.note_sample(lv, nv);
	endtask

	function automatic logic [CW-1:0] pick_normal();
		case ($urandom_range(5))
			0: return CW'($urandom_range(8) - 4);
			1: return CW'($urandom_range(512) - 256);
			2: return 16'h8000;
			3: return 16'h7fff;
			default: return CW'($urandom);
		endcase
	endfunction

	task automatic send_random(int count);
		logic [CW-1:0] lv[3], nv[3];
		for (int i = 0; i < count; i++) begin
			for (int k = 0; k < 3; k++) begin
				lv[k] = ($urandom_range(9) == 0) ? pick_normal() : CW'($urandom);
				nv[k] = pick_normal();
			end
			if ($urandom_range(19) == 0)
				nv = '{default: '0};
			send_item(lv, nv);
		end
	endtask

	task automatic send_directed();
		logic [CW-1:0] lv[3], nv[3];
		logic [CW-1:0] vals[8];
		vals = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'hc000, 16'h0001, 16'hffff,
			16'h2d41};
		for (int i = 0; i < 8; i++) begin
			lv = '{vals[i], vals[(i + 1) % 8], vals[(i + 3) % 8]};
			nv = '{vals[(i + 2) % 8], vals[(i + 5) % 8], vals[i]};
			send_item(lv, nv);
		end
		nv = '{default: '0};
		lv = '{16'h7fff, 16'h8000, 16'h4000};
		send_item(lv, nv);
		nv = '{16'h4000, 16'h0000, 16'h0000};
		send_item(lv, nv);
		nv = '{16'h0000, 16'h4000, 16'h0000};
		send_item(lv, nv);
		nv = '{16'h0000, 16'h0000, 16'h0001};
		send_item(lv, nv);
		nv = '{16'h0001, 16'hffff, 16'h0001};
		send_item(lv, nv);
		nv = '{16'h8000, 16'h8000, 16'h8000};
		lv = '{16'h8000, 16'h8000, 16'h8000};
		send_item(lv, nv);
		nv = '{16'h7fff, 16'h7fff, 16'h7fff};
		lv = '{16'h7fff, 16'h7fff, 16'h7fff};
		send_item(lv, nv);
		nv = '{16'h8000, 16'h7fff, 16'h0000};
		send_item(lv, nv);
		nv = '{16'h2000, 16'he000, 16'h3000};
		lv = '{16'h0000, 16'h4000, 16'h0000};
		send_item(lv, nv);
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_world('{world_x, world_y, world_z, degenerate, clipped});
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
		out_ready <= arst_n && !hold_off && ($urandom_range(99) >= recv_stall);
	end

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		out_ready <= 1'b0;
		local_x <= '0;
		local_y <= '0;
		local_z <= '0;
		normal_x <= '0;
		normal_y <= '0;
		normal_z <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_directed();
		send_random(150);
		send_idle = 69;
		send_random(150);
		send_idle = 0;
		recv_stall = 69;
		send_random(150);
		send_idle = 12;
		recv_stall = 12;
		send_random(100);
		send_idle = 0;
		recv_stall = 0;
		fork
			begin
				hold_off = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end
			send_random(100);
		join
		in_valid <= 1'b0;

		while (board.expected_world.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
